FILE: src/pol_pkg.sv
// Shared types and constants for the positional ordered list unit.
// Used by the controller, the top level and the checker; depends on nothing.
package pol_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result beats.
  localparam int REQ_W  = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;
  localparam int RPOS_W = 6;
  localparam int LEN_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_BACK  = 3'd1,
    REQ_INSERT    = 3'd2,
    REQ_DEL_POS   = 3'd3,
    REQ_DEL_VAL   = 3'd4,
    REQ_DEL_MAX   = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SCAN,
    S_MAX_SCAN,
    S_MAX_GO,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] rval;
    logic [RPOS_W-1:0] rpos;
    logic [LEN_W-1:0]  len;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: src/positional_ordered_list_unit.sv
// Positional ordered list: keeps up to 64 signed 32-bit values in order and
// serves add, insert, delete-at-position, delete-value and delete-max requests,
// each with one result beat. The values live in one single-port-read,
// single-port-write memory, so a request that moves or searches entries
// walks the memory one entry per cycle. With n stored values and position p,
// an insert moves the n-p entries from p upward (an append moves none), a
// delete at a position walks from p to the tail, a delete by value walks all
// n entries, and a delete-max scans all n and then walks from its maximum at k
// to the tail; a rejected request touches no entry. Requests are handled one
// at a time; a finished result waits in the output register while the next
// request is already worked on. No clearing pass is needed after reset.
// Depends on pol_pkg, pol_ctrl, pol_ram.
module positional_ordered_list_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pol_pkg::REQ_W-1:0]   in_req_type,
  input  logic signed [pol_pkg::DATA_W-1:0] in_item_value,
  input  logic [pol_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pol_pkg::STAT_W-1:0]  out_status,
  output logic signed [pol_pkg::DATA_W-1:0] out_removed_value,
  output logic [pol_pkg::RPOS_W-1:0]  out_removed_position,
  output logic [pol_pkg::LEN_W-1:0]   out_list_length
);
  import pol_pkg::*;

  logic              in_ready;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  assign in_stall = !in_ready;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req_type),
    .in_val    (in_item_value),
    .in_pos    (in_position),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  pol_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_removed_value    = out_res_r.rval;
  assign out_removed_position = out_res_r.rpos;
  assign out_list_length      = out_res_r.len;

endmodule

FILE: src/pol_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pol_ctrl.sv
// Request sequencer for the positional ordered list: decodes a request, walks
// the value memory one entry per cycle and builds the result. Uses pol_pkg.
module pol_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pol_pkg::REQ_W-1:0] in_req,
  input  logic [pol_pkg::DATA_W-1:0] in_val,
  input  logic [pol_pkg::POS_W-1:0] in_pos,
  output logic                      res_valid,
  input  logic                      res_ready,
  output pol_pkg::res_t             res,
  output pol_pkg::ram_req_t         ram_req,
  input  logic [pol_pkg::DATA_W-1:0] ram_rdata
);
  import pol_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              issue_r, issue_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              found_r, found_nxt;
  logic              take_first_r, take_first_nxt;
  logic [ADDR_W-1:0] at_r, at_nxt;
  logic [DATA_W-1:0] rval_r, rval_nxt;
  status_t           status_r, status_nxt;

  logic [ADDR_W-1:0] last_idx;
  logic [CNT_W-1:0]  ins_pos;

  assign last_idx = ADDR_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      issue_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      issue_r   <= issue_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    found_r      <= found_nxt;
    take_first_r <= take_first_nxt;
    at_r         <= at_nxt;
    rval_r       <= rval_nxt;
    status_r     <= status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    issue_nxt      = issue_r;
    rd_addr_nxt    = rd_addr_r;
    rd_pend_nxt    = 1'b0;
    found_nxt      = found_r;
    take_first_nxt = take_first_r;
    at_nxt         = at_r;
    rval_nxt       = rval_r;
    status_nxt     = status_r;
    ins_pos        = pos_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    ram_req        = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt    = in_req;
          val_nxt    = in_val;
          pos_nxt    = CNT_W'(in_pos);
          rval_nxt   = '0;
          at_nxt     = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        case (req_r)
          REQ_ADD_FRONT, REQ_ADD_BACK, REQ_INSERT: begin
            if (req_r == REQ_ADD_FRONT) begin
              ins_pos = '0;
            end else if (req_r == REQ_ADD_BACK) begin
              ins_pos = count_r;
            end else begin
              ins_pos = pos_r;
            end
            // Fullness takes priority over a bad position.
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (ins_pos > count_r) begin
              status_nxt = ST_BADPOS;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt = ins_pos;
              if (ins_pos == count_r) begin
                state_nxt = S_INS_PUT;
              end else begin
                ptr_nxt   = last_idx;
                issue_nxt = 1'b1;
                state_nxt = S_INS_SHIFT;
              end
            end
          end
          REQ_DEL_POS, REQ_DEL_VAL, REQ_DEL_MAX: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else if (req_r == REQ_DEL_POS && pos_r >= count_r) begin
              status_nxt = ST_BADPOS;
              state_nxt  = S_DONE;
            end else begin
              issue_nxt      = 1'b1;
              found_nxt      = 1'b0;
              take_first_nxt = (req_r == REQ_DEL_POS);
              ptr_nxt        = (req_r == REQ_DEL_POS) ? pos_r[ADDR_W-1:0] : '0;
              state_nxt      = (req_r == REQ_DEL_MAX) ? S_MAX_SCAN : S_DEL_SCAN;
            end
          end
          default: begin
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end
        endcase
      end

      // Move entries up by one, from the tail down to the insert position.
      // The read of entry i-1 overlaps the write of entry i+1 from the
      // previous read, so the two never touch the same address.
      S_INS_SHIFT: begin
        ram_req.we    = rd_pend_r;
        ram_req.waddr = rd_addr_r + ADDR_W'(1);
        ram_req.wdata = ram_rdata;
        if (issue_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r;
          rd_pend_nxt   = 1'b1;
          rd_addr_nxt   = ptr_r;
          if (ptr_r == pos_r[ADDR_W-1:0]) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - ADDR_W'(1);
          end
        end else if (rd_pend_r) begin
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r[ADDR_W-1:0];
        ram_req.wdata = val_r;
        count_nxt     = count_r + CNT_W'(1);
        status_nxt    = ST_OK;
        state_nxt     = S_DONE;
      end

      // Walk upward to the tail. Until the victim is found each beat of read
      // data is checked; after that it is written one place lower.
      S_DEL_SCAN: begin
        if (issue_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r;
          rd_pend_nxt   = 1'b1;
          rd_addr_nxt   = ptr_r;
          if (ptr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end
        if (rd_pend_r) begin
          if (found_r) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = rd_addr_r - ADDR_W'(1);
            ram_req.wdata = ram_rdata;
          end else if (take_first_r || (req_r == REQ_DEL_VAL && ram_rdata == val_r)) begin
            found_nxt = 1'b1;
            rval_nxt  = ram_rdata;
            at_nxt    = rd_addr_r;
          end
          if (!issue_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_MAX_SCAN: begin
        if (issue_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r;
          rd_pend_nxt   = 1'b1;
          rd_addr_nxt   = ptr_r;
          if (ptr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end
        if (rd_pend_r) begin
          // Strictly greater keeps the first of equal maxima.
          if (rd_addr_r == '0 || $signed(ram_rdata) > $signed(rval_r)) begin
            rval_nxt = ram_rdata;
            at_nxt   = rd_addr_r;
          end
          if (!issue_r) begin
            state_nxt = S_MAX_GO;
          end
        end
      end

      S_MAX_GO: begin
        ptr_nxt        = at_r;
        issue_nxt      = 1'b1;
        found_nxt      = 1'b0;
        take_first_nxt = 1'b1;
        state_nxt      = S_DEL_SCAN;
      end

      S_FIN: begin
        if (found_r) begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = ST_OK;
        end else begin
          status_nxt = ST_NOTFOUND;
          rval_nxt   = '0;
          at_nxt     = '0;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.rval   = rval_r;
  assign res.rpos   = RPOS_W'(at_r);
  assign res.len    = LEN_W'(count_r);

endmodule

FILE: src/pol_checker.sv
// Port-level checks for the positional ordered list unit, bound to the top level.
// Uses pol_pkg for the status codes and the capacity.
module pol_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [pol_pkg::REQ_W-1:0]   in_req_type,
  input logic [pol_pkg::DATA_W-1:0]  in_item_value,
  input logic [pol_pkg::POS_W-1:0]   in_position,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pol_pkg::STAT_W-1:0]  out_status,
  input logic [pol_pkg::DATA_W-1:0]  out_removed_value,
  input logic [pol_pkg::RPOS_W-1:0]  out_removed_position,
  input logic [pol_pkg::LEN_W-1:0]   out_list_length
);
  import pol_pkg::*;

  // A stalled result beat holds its status, removed value and list length.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_removed_value) && $stable(out_list_length))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_EMPTY
      || out_status == ST_BADPOS || out_status == ST_NOTFOUND || out_status == ST_FULL))
    else $error("result carries an undefined status");

  // Nothing is removed by a request that failed.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_removed_value == '0
      && out_removed_position == '0)
    else $error("failed request reports a removed value");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_list_length <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind positional_ordered_list_unit pol_checker u_pol_checker (.*);

FILE: dv/positional_ordered_list_unit_tb.sv
// Self-checking testbench for positional_ordered_list_unit: a directed table and then
// random traffic, each beat checked against a typed row or a queue-based list model.
// Depends on pol_pkg and the positional_ordered_list_unit RTL.
module positional_ordered_list_unit_tb;
  import pol_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_ITEMS = 1430;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int N_DIR        = 22;

  typedef enum logic [1:0] {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

  typedef struct packed {
    logic [REQ_W-1:0]  rq;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0]  p;
    logic              typed;
    res_t              want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type;
  logic signed [DATA_W-1:0] in_item_value;
  logic [POS_W-1:0] in_position;
  logic out_valid;
  logic out_stall;
  logic [STAT_W-1:0] out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [RPOS_W-1:0] out_removed_position;
  logic [LEN_W-1:0] out_list_length;

  logic signed [DATA_W-1:0] held_values[$];
  res_t pending_results[$];
  res_t oldest;
  dir_row_t dir_rows [N_DIR];
  int err_cnt = 0;
  int cycle_cnt = 0;
  int src_idle_pct;
  int snk_idle_pct;

  positional_ordered_list_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_item_value       (in_item_value),
    .in_position         (in_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_removed_value   (out_removed_value),
    .out_removed_position(out_removed_position),
    .out_list_length     (out_list_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** positional_ordered_list_unit: FAILED **");
      $finish;
    end
  end

  // Applies one request to the list model and returns the result it should produce.
  function automatic res_t predict_request(input logic [REQ_W-1:0] rq,
                                           input logic signed [DATA_W-1:0] v,
                                           input logic [POS_W-1:0] p);
    res_t r;
    int at;
    int i;
    bit hit;
    r = '0;
    r.status = ST_OK;
    case (rq)
      REQ_ADD_FRONT, REQ_ADD_BACK, REQ_INSERT: begin
        if (held_values.size() >= CAPACITY) r.status = ST_FULL;
        else if (rq == REQ_ADD_FRONT) held_values.push_front(v);
        else if (rq == REQ_ADD_BACK) held_values.push_back(v);
        else if (int'(p) > held_values.size()) r.status = ST_BADPOS;
        else held_values.insert(int'(p), v);
      end
      REQ_DEL_POS, REQ_DEL_VAL, REQ_DEL_MAX: begin
        if (held_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = 1'b1;
          at = 0;
          if (rq == REQ_DEL_POS) begin
            if (int'(p) >= held_values.size()) begin
              r.status = ST_BADPOS;
              hit = 1'b0;
            end else begin
              at = int'(p);
            end
          end else if (rq == REQ_DEL_VAL) begin
            hit = 1'b0;
            for (i = 0; i < held_values.size() && !hit; i++) begin
              if (held_values[i] == v) begin
                at = i;
                hit = 1'b1;
              end
            end
            if (!hit) r.status = ST_NOTFOUND;
          end else begin
            // Strict compare keeps the first of several equal maxima.
            for (i = 1; i < held_values.size(); i++) begin
              if (held_values[i] > held_values[at]) at = i;
            end
          end
          if (hit) begin
            r.rval = held_values[at];
            r.rpos = RPOS_W'(at);
            held_values.delete(at);
          end
        end
      end
      default: ;
    endcase
    r.len = LEN_W'(held_values.size());
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      // A narrow range makes ties and repeated values common.
      1: v = $signed(DATA_W'($urandom_range(0, 15))) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic issue_request(input logic [REQ_W-1:0] rq, input logic signed [DATA_W-1:0] v,
                               input logic [POS_W-1:0] p, input logic use_typed,
                               input res_t typed_want);
    res_t r;
    r = predict_request(rq, v, p);
    pending_results.push_back(use_typed ? typed_want : r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq;
    in_item_value <= v;
    in_position   <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < snk_idle_pct);
  end

  task automatic flag_mismatch(input string fname, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, exp_v, act_v);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d value %0h pos %0d len %0d",
                 $time, out_status, out_removed_value, out_removed_position, out_list_length);
        err_cnt++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status)
          flag_mismatch("status", DATA_W'(oldest.status), DATA_W'(out_status));
        if (out_removed_value !== oldest.rval)
          flag_mismatch("removed_value", oldest.rval, out_removed_value);
        if (out_removed_position !== oldest.rpos)
          flag_mismatch("removed_position", DATA_W'(oldest.rpos), DATA_W'(out_removed_position));
        if (out_list_length !== oldest.len)
          flag_mismatch("list_length", DATA_W'(oldest.len), DATA_W'(out_list_length));
      end
    end
  end

  initial begin
    int i;
    int phase;
    int counted;
    int seg_left;
    int len;
    int add_pct;
    trend_t trend;
    logic [REQ_W-1:0] rq;
    logic signed [DATA_W-1:0] v;
    logic [POS_W-1:0] p;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_item_value = '0;
    in_position = '0;
    src_idle_pct = 18;
    snk_idle_pct = 82;

    // The list reads front to back; contents after each untyped row are noted on the right.
    dir_rows = '{
      '{REQ_DEL_POS,   32'd0,        7'd0,   1'b1, '{ST_EMPTY,  32'd0, 6'd0, 7'd0}},
      '{REQ_DEL_VAL,   32'd5,        7'd0,   1'b1, '{ST_EMPTY,  32'd0, 6'd0, 7'd0}},
      '{REQ_DEL_MAX,   32'd0,        7'd0,   1'b1, '{ST_EMPTY,  32'd0, 6'd0, 7'd0}},
      '{REQ_INSERT,    32'd9,        7'd1,   1'b1, '{ST_BADPOS, 32'd0, 6'd0, 7'd0}},
      '{REQ_SPARE_6,   32'd3,        7'd2,   1'b1, '{ST_OK,     32'd0, 6'd0, 7'd0}},
      '{REQ_SPARE_7,   32'hFFFFFFFF, 7'd127, 1'b1, '{ST_OK,     32'd0, 6'd0, 7'd0}},
      '{REQ_INSERT,    32'd42,       7'd0,   1'b1, '{ST_OK,     32'd0, 6'd0, 7'd1}},
      '{REQ_ADD_FRONT, VAL_MAX,      7'd0,   1'b1, '{ST_OK,     32'd0, 6'd0, 7'd2}},
      '{REQ_ADD_BACK,  VAL_MIN,      7'd0,   1'b1, '{ST_OK,     32'd0, 6'd0, 7'd3}},
      '{REQ_INSERT,    32'hFFFFFFFF, 7'd3,   1'b1, '{ST_OK,     32'd0, 6'd0, 7'd4}},
      '{REQ_INSERT,    32'd7,        7'd127, 1'b1, '{ST_BADPOS, 32'd0, 6'd0, 7'd4}},
      '{REQ_DEL_POS,   32'd0,        7'd4,   1'b1, '{ST_BADPOS, 32'd0, 6'd0, 7'd4}},
      '{REQ_DEL_POS,   32'd0,        7'd127, 1'b1, '{ST_BADPOS, 32'd0, 6'd0, 7'd4}},
      '{REQ_DEL_VAL,   32'd12345,    7'd0,   1'b1, '{ST_NOTFOUND, 32'd0, 6'd0, 7'd4}},
      '{REQ_DEL_MAX,   32'd0,        7'd0,   1'b0, '0},  // 42 min -1
      '{REQ_ADD_BACK,  32'd42,       7'd0,   1'b0, '0},  // 42 min -1 42
      '{REQ_DEL_MAX,   32'd0,        7'd0,   1'b0, '0},  // min -1 42
      '{REQ_DEL_VAL,   32'hFFFFFFFF, 7'd0,   1'b0, '0},  // min 42
      '{REQ_INSERT,    32'd0,        7'd1,   1'b0, '0},  // min 0 42
      '{REQ_DEL_POS,   32'd0,        7'd1,   1'b0, '0},  // min 42
      '{REQ_DEL_VAL,   VAL_MIN,      7'd0,   1'b0, '0},  // 42
      '{REQ_DEL_POS,   32'd0,        7'd0,   1'b0, '0}   // empty
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      issue_request(dir_rows[i].rq, dir_rows[i].v, dir_rows[i].p, dir_rows[i].typed,
                    dir_rows[i].want);
    end

    seg_left = 0;
    trend = TREND_GROW;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 18;
          snk_idle_pct = 82;
        end
        1: begin
          src_idle_pct = 82;
          snk_idle_pct = 18;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_ITEMS / 3) begin
        // Runs of mostly adds or mostly deletes carry the list between empty and full.
        if (seg_left == 0) begin
          trend = trend_t'($urandom_range(0, 2));
          seg_left = $urandom_range(40, 120);
        end
        seg_left--;
        len = held_values.size();
        if ($urandom_range(0, 99) < 4) begin
          rq = REQ_W'($urandom_range(0, 7));
          v = $urandom;
          p = POS_W'($urandom_range(0, 127));
        end else begin
          add_pct = (trend == TREND_GROW) ? 75 : (trend == TREND_SHRINK) ? 25 : 50;
          if ($urandom_range(0, 99) < add_pct) begin
            case ($urandom_range(0, 2))
              0: rq = REQ_ADD_FRONT;
              1: rq = REQ_ADD_BACK;
              default: rq = REQ_INSERT;
            endcase
            v = pick_value();
            p = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, len))
                                             : POS_W'($urandom_range(0, 127));
          end else begin
            case ($urandom_range(0, 2))
              0: rq = REQ_DEL_POS;
              1: rq = REQ_DEL_VAL;
              default: rq = REQ_DEL_MAX;
            endcase
            p = (len > 0 && $urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, len - 1))
                                                        : POS_W'($urandom_range(0, 127));
            v = (len > 0 && $urandom_range(0, 99) < 70) ?
                held_values[$urandom_range(0, len - 1)] : pick_value();
          end
        end
        issue_request(rq, v, p, 1'b0, '0);
        if (rq <= REQ_DEL_MAX) counted++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** positional_ordered_list_unit: PASSED **");
    end else begin
      $display("** positional_ordered_list_unit: FAILED **");
    end
    $finish;
  end

endmodule
